// ===== hw/rtl/pidsep_pkg.sv =====
// ----------------------------------------------------------------------------
// pidsep_pkg
// shared widths, register codes, reset values and types of the pid controller
// ----------------------------------------------------------------------------
package pidsep_pkg;

	// field widths
	localparam int FLOW_W   = 13;
	localparam int MEAS_W   = 20;
	localparam int GAIN_W   = 16;
	localparam int THR_W    = 4;
	localparam int CFG_W    = 20;
	localparam int OUT_W    = 32;

	// stream payload widths, tdata padded to whole bytes
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_TUSER_W = 1;

	// internal arithmetic
	localparam int COEF_W      = 16;   // every coefficient fed to the serial mac
	localparam int DIGIT_W     = 4;    // coefficient bits consumed per cycle
	localparam int ACC_W       = 58;   // holds the exact sum of the three products
	localparam int ERR_W       = 24;   // error range fits in 24 signed bits
	localparam int SETP_W      = 22;   // offset plus scaled slope product
	localparam int SUM_W       = 40;   // integral register
	localparam int SETP_SHIFT  = 8;    // q0.24 slope times flow down to q16
	localparam int SETP_PROD_W = 29;   // slope times flow
	localparam int VOLT_LSB    = 16;   // q16 whole-volt position
	localparam int Q_SHIFT     = 12;   // q4.12 gains

	// register indexes
	typedef enum logic [2:0] {
		CFG_GAIN_P    = 3'd0,
		CFG_GAIN_I    = 3'd1,
		CFG_GAIN_D    = 3'd2,
		CFG_UPPER     = 3'd3,
		CFG_LOWER     = 3'd4,
		CFG_THRESHOLD = 3'd5,
		CFG_SLOPE     = 3'd6,
		CFG_OFFSET    = 3'd7
	} cfg_index_t;

	localparam int CFG_INDEX_W = 3;

	// register reset values
	localparam logic [GAIN_W-1:0] RST_GAIN_P    = 16'd410;
	localparam logic [GAIN_W-1:0] RST_GAIN_I    = 16'd614;
	localparam logic [GAIN_W-1:0] RST_GAIN_D    = 16'd819;
	localparam logic [MEAS_W-1:0] RST_UPPER     = 20'd655360;
	localparam logic [MEAS_W-1:0] RST_LOWER     = 20'd0;
	localparam logic [THR_W-1:0]  RST_THRESHOLD = 4'd2;
	localparam logic [GAIN_W-1:0] RST_SLOPE     = 16'd6711;
	localparam logic [MEAS_W-1:0] RST_OFFSET    = 20'd69992;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_proportional;
		logic [GAIN_W-1:0] gain_integral;
		logic [GAIN_W-1:0] gain_derivative;
		logic [MEAS_W-1:0] upper_limit;
		logic [MEAS_W-1:0] lower_limit;
		logic [THR_W-1:0]  separation_threshold;
		logic [GAIN_W-1:0] setpoint_slope;
		logic [MEAS_W-1:0] setpoint_offset;
	} cfg_t;

	// command to the serial mac
	typedef struct packed {
		logic start;   // load operands and begin
		logic clear;   // start from an empty accumulator
	} mac_cmd_t;

endpackage

// ===== hw/rtl/pidsep_cfg.sv =====
// ----------------------------------------------------------------------------
// pidsep_cfg
// configuration register bank with write port
// ----------------------------------------------------------------------------
module pidsep_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pidsep_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pidsep_pkg::CFG_W-1:0]         cfg_wdata,
	output pidsep_pkg::cfg_t                     cfg
);

	pidsep_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_proportional    <= pidsep_pkg::RST_GAIN_P;
			cfg_q.gain_integral        <= pidsep_pkg::RST_GAIN_I;
			cfg_q.gain_derivative      <= pidsep_pkg::RST_GAIN_D;
			cfg_q.upper_limit          <= pidsep_pkg::RST_UPPER;
			cfg_q.lower_limit          <= pidsep_pkg::RST_LOWER;
			cfg_q.separation_threshold <= pidsep_pkg::RST_THRESHOLD;
			cfg_q.setpoint_slope       <= pidsep_pkg::RST_SLOPE;
			cfg_q.setpoint_offset      <= pidsep_pkg::RST_OFFSET;
		end else if (cfg_we) begin
			case (pidsep_pkg::cfg_index_t'(cfg_index))
				pidsep_pkg::CFG_GAIN_P: begin
					cfg_q.gain_proportional <= cfg_wdata[pidsep_pkg::GAIN_W-1:0];
				end
				pidsep_pkg::CFG_GAIN_I: begin
					cfg_q.gain_integral <= cfg_wdata[pidsep_pkg::GAIN_W-1:0];
				end
				pidsep_pkg::CFG_GAIN_D: begin
					cfg_q.gain_derivative <= cfg_wdata[pidsep_pkg::GAIN_W-1:0];
				end
				pidsep_pkg::CFG_UPPER: begin
					cfg_q.upper_limit <= cfg_wdata[pidsep_pkg::MEAS_W-1:0];
				end
				pidsep_pkg::CFG_LOWER: begin
					cfg_q.lower_limit <= cfg_wdata[pidsep_pkg::MEAS_W-1:0];
				end
				pidsep_pkg::CFG_THRESHOLD: begin
					cfg_q.separation_threshold <= cfg_wdata[pidsep_pkg::THR_W-1:0];
				end
				pidsep_pkg::CFG_SLOPE: begin
					cfg_q.setpoint_slope <= cfg_wdata[pidsep_pkg::GAIN_W-1:0];
				end
				pidsep_pkg::CFG_OFFSET: begin
					cfg_q.setpoint_offset <= cfg_wdata[pidsep_pkg::MEAS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/pidsep_mac.sv =====
// ----------------------------------------------------------------------------
// pidsep_mac
// digit-serial multiply-accumulate: signed multiplicand times unsigned coefficient
// ----------------------------------------------------------------------------
module pidsep_mac #(
	parameter int DIGIT_W = pidsep_pkg::DIGIT_W
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pidsep_pkg::mac_cmd_t                 cmd,
	input  logic signed [pidsep_pkg::ACC_W-1:0]  mcand,
	input  logic [pidsep_pkg::COEF_W-1:0]        coef,
	output logic signed [pidsep_pkg::ACC_W-1:0]  acc,
	output logic                                 done
);

	localparam int NDIG  = pidsep_pkg::COEF_W / DIGIT_W;
	localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

	logic signed [pidsep_pkg::ACC_W-1:0] mcand_q;
	logic signed [pidsep_pkg::ACC_W-1:0] acc_q;
	logic [pidsep_pkg::COEF_W-1:0]       coef_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic                                busy_q;
	logic                                done_q;
	logic signed [DIGIT_W:0]             digit;
	logic signed [pidsep_pkg::ACC_W-1:0] partial;

	// lowest coefficient digit, zero-extended so it multiplies as unsigned
	assign digit   = signed'({1'b0, coef_q[DIGIT_W-1:0]});
	assign partial = mcand_q * pidsep_pkg::ACC_W'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NDIG - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// operand shift registers and accumulator
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q <= mcand;
			coef_q  <= coef;
			if (cmd.clear) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q   <= acc_q + partial;
			mcand_q <= mcand_q <<< DIGIT_W;
			coef_q  <= coef_q >> DIGIT_W;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/pid_integral_separation_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_integral_separation_antiwindup
// positional pid with integral separation and direction-limited anti-windup
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  s_       | in        | s_tvalid / s_tready       | flow_setpoint, measured_voltage
//  m_       | out       | m_tvalid / m_tready       | control_voltage, error_value;
//           |           |                           | tuser: integral_active
//  cfg_     | in        | cfg_we (no back-pressure) | cfg_index, cfg_wdata
//
//  one item at a time: the next input transfer is taken only once the sequencer has
//  returned to idle; the four coefficient products, of which the integral one is skipped
//  when the integral is separated, run through the one digit-serial mac
//  the result leaves through an output register, so the next input transfer is
//  taken while a result still waits on m_tready
//  arst_n clears controller state (previous measurement, previous error, integral)
//  and loads the register reset values
//
module pid_integral_separation_antiwindup #(
	parameter int DIGIT_W = pidsep_pkg::DIGIT_W
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [pidsep_pkg::IN_TDATA_W-1:0]     s_tdata,   // flow_setpoint, measured_voltage
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [pidsep_pkg::OUT_TDATA_W-1:0]    m_tdata,   // control_voltage, error_value
	output logic [pidsep_pkg::OUT_TUSER_W-1:0]    m_tuser,   // integral_active
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [pidsep_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pidsep_pkg::CFG_W-1:0]          cfg_wdata
);

	localparam int ACC_W = pidsep_pkg::ACC_W;
	localparam int ERR_W = pidsep_pkg::ERR_W;
	localparam int SUM_W = pidsep_pkg::SUM_W;
	localparam int OUT_W = pidsep_pkg::OUT_W;
	localparam int SH_W  = ACC_W - pidsep_pkg::Q_SHIFT;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// sequencer: setpoint product, integral update, then kp, kd and (unless separated) ki products
	typedef enum logic [2:0] {
		S_IDLE,
		S_SETP,
		S_SUM,
		S_PROP,
		S_DERV,
		S_INTG,
		S_OUT
	} state_t;

	state_t                               state_q;
	pidsep_pkg::cfg_t                     cfg;
	pidsep_pkg::mac_cmd_t                 cmd_q;
	logic signed [ACC_W-1:0]              mcand_q;
	logic [pidsep_pkg::COEF_W-1:0]        coef_q;
	logic signed [ACC_W-1:0]              mac_acc;
	logic                                 mac_done;

	// controller state
	logic [pidsep_pkg::MEAS_W-1:0]        prev_meas_q;
	logic [pidsep_pkg::MEAS_W-1:0]        meas_next_q;   // applies from the next item on
	logic signed [ERR_W-1:0]              prev_err_q;
	logic signed [ERR_W-1:0]              err_q;
	logic signed [SUM_W-1:0]              sum_q;
	logic                                 active_q;

	// output register
	logic                                 m_tvalid_q;
	logic signed [OUT_W-1:0]              ctrl_q;
	logic signed [OUT_W-1:0]              err_out_q;
	logic                                 act_out_q;

	logic [pidsep_pkg::SETP_W-1:0]        setpoint;
	logic signed [ERR_W-1:0]              err_calc;
	logic [ERR_W-1:0]                     err_mag;
	logic                                 active_calc;
	logic                                 add_calc;
	logic signed [SUM_W:0]                sum_add;
	logic signed [SUM_W-1:0]              sum_sat;
	logic signed [ERR_W:0]                err_diff;
	logic signed [SH_W-1:0]               acc_sh;
	logic [SH_W-OUT_W:0]                  acc_hi;
	logic signed [OUT_W-1:0]              ctrl_calc;

	pidsep_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pidsep_mac #(
		.DIGIT_W (DIGIT_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_q),
		.mcand  (mcand_q),
		.coef   (coef_q),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// setpoint = offset + slope*flow in q16, error against the stored measurement
	assign setpoint = pidsep_pkg::SETP_W'(cfg.setpoint_offset)
		+ pidsep_pkg::SETP_W'(mac_acc[pidsep_pkg::SETP_PROD_W-1:pidsep_pkg::SETP_SHIFT]);
	assign err_calc = signed'(ERR_W'(setpoint)) - signed'(ERR_W'(prev_meas_q));

	// separation: whole-volt part of |error| against the threshold
	assign err_mag     = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
	assign active_calc = err_mag[ERR_W-1:pidsep_pkg::VOLT_LSB]
		<= (ERR_W - pidsep_pkg::VOLT_LSB)'(cfg.separation_threshold);

	// anti-windup: outside the window only errors pointing back inside integrate
	always_comb begin
		if (prev_meas_q > cfg.upper_limit) begin
			add_calc = err_q[ERR_W-1];
		end else if (prev_meas_q < cfg.lower_limit) begin
			add_calc = !err_q[ERR_W-1] && (err_q != '0);
		end else begin
			add_calc = 1'b1;
		end
	end

	// saturating integral update
	assign sum_add = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err_q);
	always_comb begin
		if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
			sum_sat = sum_add[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_add[SUM_W-1:0];
		end
	end

	assign err_diff = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_err_q);

	// floor divide by 2^12 is an arithmetic shift, then clamp to 32 bits
	assign acc_sh = signed'(mac_acc[ACC_W-1:pidsep_pkg::Q_SHIFT]);
	assign acc_hi = acc_sh[SH_W-1:OUT_W-1];
	always_comb begin
		if ((&acc_hi) || !(|acc_hi)) begin
			ctrl_calc = acc_sh[OUT_W-1:0];
		end else begin
			ctrl_calc = acc_sh[SH_W-1] ? OUT_MIN : OUT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			mcand_q     <= '0;
			coef_q      <= '0;
			prev_meas_q <= '0;
			meas_next_q <= '0;
			prev_err_q  <= '0;
			err_q       <= '0;
			sum_q       <= '0;
			active_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			ctrl_q      <= '0;
			err_out_q   <= '0;
			act_out_q   <= 1'b0;
		end else begin
			cmd_q <= '0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						// slope times flow first
						meas_next_q <= s_tdata[pidsep_pkg::FLOW_W +: pidsep_pkg::MEAS_W];
						mcand_q     <= ACC_W'(s_tdata[pidsep_pkg::FLOW_W-1:0]);
						coef_q      <= cfg.setpoint_slope;
						cmd_q       <= '{start: 1'b1, clear: 1'b1};
						state_q     <= S_SETP;
					end
				end
				S_SETP: begin
					if (mac_done) begin
						err_q   <= err_calc;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					active_q <= active_calc;
					if (active_calc && add_calc) begin
						sum_q <= sum_sat;
					end
					mcand_q <= ACC_W'(err_q);
					coef_q  <= cfg.gain_proportional;
					cmd_q   <= '{start: 1'b1, clear: 1'b1};
					state_q <= S_PROP;
				end
				S_PROP: begin
					if (mac_done) begin
						mcand_q <= ACC_W'(err_diff);
						coef_q  <= cfg.gain_derivative;
						cmd_q   <= '{start: 1'b1, clear: 1'b0};
						state_q <= S_DERV;
					end
				end
				S_DERV: begin
					if (mac_done) begin
						if (active_q) begin
							mcand_q <= ACC_W'(sum_q);
							coef_q  <= cfg.gain_integral;
							cmd_q   <= '{start: 1'b1, clear: 1'b0};
							state_q <= S_INTG;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_INTG: begin
					if (mac_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// wait for the output register to free up
					if (!m_tvalid_q || m_tready) begin
						ctrl_q      <= ctrl_calc;
						err_out_q   <= OUT_W'(err_q);
						act_out_q   <= active_q;
						m_tvalid_q  <= 1'b1;
						prev_err_q  <= err_q;
						prev_meas_q <= meas_next_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {err_out_q, ctrl_q};
	assign m_tuser  = act_out_q;

endmodule

// ===== hw/rtl/pidsep_checker.sv =====
// ----------------------------------------------------------------------------
// pidsep_checker
// port-level checks of the pid controller, bound to the top level
// ----------------------------------------------------------------------------
module pidsep_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [pidsep_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic [pidsep_pkg::OUT_TUSER_W-1:0]    m_tuser
);

	logic signed [pidsep_pkg::OUT_W-1:0] err_w;

	assign err_w = signed'(m_tdata[pidsep_pkg::OUT_TDATA_W-1:pidsep_pkg::OUT_W]);

	// no result is offered while in reset
	assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result offered during reset");

	// the controller works on one item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input taken while an item is in progress");

	// a separated integral only happens at one volt of error or more
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (err_w >= 32'sd65536) || (err_w <= -32'sd65536))
		else $error("integral dropped with a small error");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind pid_integral_separation_antiwindup pidsep_checker u_pidsep_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/sv/pidsep_result_checker.sv =====
// ----------------------------------------------------------------------------
// pidsep_result_checker
// watches the stream and register ports of the pid controller, predicts every
// result from its own copy of the controller state and compares field by field
// ----------------------------------------------------------------------------
module pidsep_result_checker import pidsep_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // flow_setpoint, measured_voltage
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // control_voltage, error_value
	input  logic [OUT_TUSER_W-1:0] m_tuser,   // integral_active
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	output int                     faults,
	output int                     outstanding,
	output int                     results_checked,
	output int                     separated_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SUM_HI = 64'sd549755813887;
	localparam longint SUM_LO = -64'sd549755813888;
	localparam longint CTL_HI = 64'sd2147483647;
	localparam longint CTL_LO = -64'sd2147483648;

	typedef struct packed {
		logic [OUT_W-1:0] control_voltage;
		logic [OUT_W-1:0] error_value;
		logic             integral_active;
	} pid_out_t;

	cfg_t              regs;
	logic [MEAS_W-1:0] last_meas;
	longint            last_err;
	longint            err_sum;
	pid_out_t          control_queue[$];

	// one controller step: setpoint, error, separation, limited integral, output
	function automatic pid_out_t pid_step(input logic [FLOW_W-1:0] flow,
			input logic [MEAS_W-1:0] meas);
		longint setp, err, mag, acc, ctl;
		longint kp, ki, kd, slope, flow_l, prev, upper, lower, thr;
		logic active, integrate;
		pid_out_t r;
		kp = regs.gain_proportional;
		ki = regs.gain_integral;
		kd = regs.gain_derivative;
		slope = regs.setpoint_slope;
		upper = regs.upper_limit;
		lower = regs.lower_limit;
		thr = regs.separation_threshold;
		flow_l = flow;
		prev = last_meas;
		setp = regs.setpoint_offset;
		setp = setp + ((slope * flow_l) >>> 8);
		err = setp - prev;
		mag = (err < 0) ? -err : err;
		active = (mag >>> 16) <= thr;
		if (active) begin
			// direction-limited integration outside the measurement window
			if (prev > upper)
				integrate = err < 0;
			else if (prev < lower)
				integrate = err > 0;
			else
				integrate = 1'b1;
			if (integrate) begin
				err_sum = err_sum + err;
				if (err_sum > SUM_HI) err_sum = SUM_HI;
				if (err_sum < SUM_LO) err_sum = SUM_LO;
			end
		end
		acc = kp * err + kd * (err - last_err);
		if (active)
			acc = acc + ki * err_sum;
		ctl = acc >>> 12;
		if (ctl > CTL_HI) ctl = CTL_HI;
		if (ctl < CTL_LO) ctl = CTL_LO;
		last_err = err;
		last_meas = meas;
		r.control_voltage = ctl[OUT_W-1:0];
		r.error_value = err[OUT_W-1:0];
		r.integral_active = active;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pid_out_t want;
		int bad;
		if (!arst_n) begin
			regs = '{gain_proportional: RST_GAIN_P, gain_integral: RST_GAIN_I,
				gain_derivative: RST_GAIN_D, upper_limit: RST_UPPER, lower_limit: RST_LOWER,
				separation_threshold: RST_THRESHOLD, setpoint_slope: RST_SLOPE,
				setpoint_offset: RST_OFFSET};
			last_meas = '0;
			last_err = 0;
			err_sum = 0;
			control_queue.delete();
			outstanding <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_GAIN_P:    regs.gain_proportional = cfg_wdata[GAIN_W-1:0];
					CFG_GAIN_I:    regs.gain_integral = cfg_wdata[GAIN_W-1:0];
					CFG_GAIN_D:    regs.gain_derivative = cfg_wdata[GAIN_W-1:0];
					CFG_UPPER:     regs.upper_limit = cfg_wdata[MEAS_W-1:0];
					CFG_LOWER:     regs.lower_limit = cfg_wdata[MEAS_W-1:0];
					CFG_THRESHOLD: regs.separation_threshold = cfg_wdata[THR_W-1:0];
					CFG_SLOPE:     regs.setpoint_slope = cfg_wdata[GAIN_W-1:0];
					CFG_OFFSET:    regs.setpoint_offset = cfg_wdata[MEAS_W-1:0];
					default: ;
				endcase
			end
			// the result side goes first: a result never belongs to an item taken at the same edge
			if (m_tvalid && m_tready) begin
				if (control_queue.size() == 0) begin
					$display("%0t unexpected result: control_voltage %0d error_value %0d",
						$time, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
					bad++;
				end else begin
					want = control_queue.pop_front();
					if (m_tdata[31:0] !== want.control_voltage) begin
						$display("%0t control_voltage mismatch: expected %0d actual %0d", $time,
							$signed(want.control_voltage), $signed(m_tdata[31:0]));
						bad++;
					end
					if (m_tdata[63:32] !== want.error_value) begin
						$display("%0t error_value mismatch: expected %0d actual %0d", $time,
							$signed(want.error_value), $signed(m_tdata[63:32]));
						bad++;
					end
					if (m_tuser[0] !== want.integral_active) begin
						$display("%0t integral_active mismatch: expected %0b actual %0b", $time,
							want.integral_active, m_tuser[0]);
						bad++;
					end
					if (!want.integral_active)
						separated_seen <= separated_seen + 1;
				end
				results_checked <= results_checked + 1;
			end
			if (s_tvalid && s_tready)
				control_queue.push_back(pid_step(s_tdata[FLOW_W-1:0],
					s_tdata[FLOW_W+MEAS_W-1:FLOW_W]));
			outstanding <= control_queue.size();
			faults <= faults + bad;
		end
	end

endmodule

// ===== tb/sv/tb_pid_integral_separation_antiwindup.sv =====
// ----------------------------------------------------------------------------
// tb_pid_integral_separation_antiwindup
// regression of the pid controller: directed corner items and long tracking
// runs under several register settings, with random stalls on both streams
// ----------------------------------------------------------------------------
module tb_pid_integral_separation_antiwindup;
	timeunit 1ns;
	timeprecision 1ps;
	import pidsep_pkg::*;

	localparam int STALL_LIMIT = 2000;   // cycles without any transfer
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 250;
	localparam int DRAIN_CYCLES = 40;    // a bit more than one item through the mac

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // flow_setpoint, measured_voltage
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;   // control_voltage, error_value
	logic [OUT_TUSER_W-1:0] m_tuser;   // integral_active
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;

	int faults;
	int outstanding;
	int results_checked;
	int separated_seen;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int settings_used;
	int quiet_cycles;
	cfg_t cur_cfg;                       // register values in force, used to shape stimulus
	logic [FLOW_W-1:0] held_flow;        // flow kept steady across a tracking run

	pid_integral_separation_antiwindup DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pidsep_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.faults          (faults),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.separated_seen  (separated_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// watchdog: a hang shows up as a long stretch with no transfer on either stream
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t no transfer for %0d cycles", $time, quiet_cycles);
				$display("pid_integral_separation_antiwindup regression: fail");
				$finish;
			end
		end
	end

	// drop valid and wait until every predicted result has left the block;
	// the first edge lets the checker count a transfer taken at this very edge
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// one register write per cycle; the caller lowers the write enable
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		wait_idle();
		write_reg(CFG_GAIN_P, CFG_W'(c.gain_proportional));
		write_reg(CFG_GAIN_I, CFG_W'(c.gain_integral));
		write_reg(CFG_GAIN_D, CFG_W'(c.gain_derivative));
		write_reg(CFG_UPPER, CFG_W'(c.upper_limit));
		write_reg(CFG_LOWER, CFG_W'(c.lower_limit));
		write_reg(CFG_THRESHOLD, CFG_W'(c.separation_threshold));
		write_reg(CFG_SLOPE, CFG_W'(c.setpoint_slope));
		write_reg(CFG_OFFSET, CFG_W'(c.setpoint_offset));
		cfg_we <= 1'b0;
		cur_cfg = c;
		settings_used++;
	endtask

	// one input transfer, with random sender gaps in front of it
	task automatic send_item(input logic [FLOW_W-1:0] flow, input logic [MEAS_W-1:0] meas);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, meas, flow};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// register value with extra weight on both ends of its range
	function automatic logic [CFG_W-1:0] pick_value(input int unsigned maxv);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CFG_W'(maxv);
			default: return CFG_W'($urandom_range(0, maxv));
		endcase
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		c.gain_proportional = GAIN_W'(pick_value(16'hFFFF));
		c.gain_integral = GAIN_W'(pick_value(16'hFFFF));
		c.gain_derivative = GAIN_W'(pick_value(16'hFFFF));
		c.upper_limit = MEAS_W'(pick_value(20'hFFFFF));
		c.lower_limit = MEAS_W'(pick_value(20'hFFFFF));
		c.separation_threshold = THR_W'(pick_value(15));
		c.setpoint_slope = GAIN_W'(pick_value(16'hFFFF));
		c.setpoint_offset = MEAS_W'(pick_value(20'hFFFFF));
		return c;
	endfunction

	// mostly tracking runs: the measurement follows the setpoint of a steady flow
	// with some noise, so the next error stays small and the integral is exercised;
	// the rest are unrelated flow and measurement values
	task automatic send_random();
		longint setp, slope_l, flow_l, noise;
		int unsigned span, draw;
		logic [FLOW_W-1:0] flow;
		logic [MEAS_W-1:0] meas;
		if ($urandom_range(0, 99) < 70) begin
			if ($urandom_range(0, 9) == 0)
				held_flow = ($urandom_range(0, 3) == 0) ? FLOW_W'($urandom_range(0, 8191))
					: FLOW_W'($urandom_range(0, 255));
			flow = held_flow;
			span = 1 << $urandom_range(6, 19);
			draw = $urandom_range(0, 2 * span);
			noise = draw;
			noise = noise - span;
			slope_l = cur_cfg.setpoint_slope;
			flow_l = flow;
			setp = cur_cfg.setpoint_offset;
			setp = setp + ((slope_l * flow_l) >>> 8) + noise;
			if (setp < 0) setp = 0;
			if (setp > 64'sd1048575) setp = 64'sd1048575;
			meas = setp[MEAS_W-1:0];
		end else begin
			flow = FLOW_W'($urandom_range(0, 8191));
			meas = MEAS_W'($urandom_range(0, 20'hFFFFF));
		end
		send_item(flow, meas);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		items_sent = 0;
		settings_used = 1;
		held_flow = '0;
		send_idle_pct = 23;
		recv_idle_pct = 69;
		cur_cfg = '{gain_proportional: RST_GAIN_P, gain_integral: RST_GAIN_I,
			gain_derivative: RST_GAIN_D, upper_limit: RST_UPPER, lower_limit: RST_LOWER,
			separation_threshold: RST_THRESHOLD, setpoint_slope: RST_SLOPE,
			setpoint_offset: RST_OFFSET};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: field extremes, large errors separate the integral
		send_item(13'd0, 20'd0);
		send_item(13'h1FFF, 20'hFFFFF);
		send_item(13'd0, 20'hA8000);
		send_item(13'h1FFF, 20'd0);

		// full gains, lower limit above the upper one (2 V and 4 V), widest
		// threshold; setpoint is 1 V plus flow/256 V
		apply_config('{gain_proportional: 16'hFFFF, gain_integral: 16'hFFFF,
			gain_derivative: 16'hFFFF, upper_limit: 20'h20000, lower_limit: 20'h40000,
			separation_threshold: 4'hF, setpoint_slope: 16'hFFFF,
			setpoint_offset: 20'h10000});
		send_item(13'd256, 20'h28000);
		send_item(13'd512, 20'h28000);    // positive error above the upper limit: held
		send_item(13'd0, 20'h18000);      // negative error above the upper limit: added
		send_item(13'd0, 20'h18000);      // negative error below the lower limit: held
		send_item(13'd512, 20'h30000);    // positive error below the lower limit: added
		send_item(13'h1FFF, 20'd0);       // error well past the threshold
		send_item(13'd0, 20'hFFFFF);
		send_item(13'd0, 20'd0);          // about -15 V, still within the threshold
		send_item(13'h1FFF, 20'h10000);

		// zero gains and slope, top offset, zero threshold
		apply_config('{gain_proportional: 16'd0, gain_integral: 16'd0, gain_derivative: 16'd0,
			upper_limit: 20'hFFFFF, lower_limit: 20'd0, separation_threshold: 4'd0,
			setpoint_slope: 16'd0, setpoint_offset: 20'hFFFFF});
		send_item(13'h1FFF, 20'hFFFFF);
		send_item(13'd0, 20'hF8000);      // error exactly zero
		send_item(13'd4096, 20'h0FFFF);   // half a volt of error passes a zero threshold
		send_item(13'd1, 20'd0);

		// random phases, a new idling pattern for each of the first two pairs of phases, no idling after that
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			apply_config(random_config());
			case (ph / 2)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input transfers over %0d register settings, %0d results checked",
			items_sent, settings_used, results_checked);
		$display("%0d of those results had the integral separated", separated_seen);
		if (outstanding != 0)
			$display("%0t %0d expected results never arrived", $time, outstanding);
		if (faults == 0 && outstanding == 0) begin
			$display("pid_integral_separation_antiwindup regression: pass");
		end else begin
			$display("pid_integral_separation_antiwindup regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pidsep_pkg.sv
hw/rtl/pidsep_cfg.sv
hw/rtl/pidsep_mac.sv
hw/rtl/pid_integral_separation_antiwindup.sv
hw/rtl/pidsep_checker.sv
tb/sv/pidsep_result_checker.sv
tb/sv/tb_pid_integral_separation_antiwindup.sv
